/* rtl/core/tlru_pkg.sv */
// package for the two-list lru tracker: codes, state type, control structs
`default_nettype none
package tlru_pkg;

  localparam int TLRU_ENTRIES = 64;
  localparam int IDX_W        = 6;
  localparam int LVL_W        = 2;

  localparam logic [LVL_W-1:0] LVL_NONE     = 2'd0;
  localparam logic [LVL_W-1:0] LVL_INACTIVE = 2'd1;
  localparam logic [LVL_W-1:0] LVL_ACTIVE   = 2'd2;

  localparam logic FUNC_PROMOTE = 1'b0;
  localparam logic FUNC_DEMOTE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REMOVE,
    ST_APPEND,
    ST_FINISH
  } tlru_state_t;

  typedef struct packed {
    logic clr_we;
    logic lookup;
    logic remove;
    logic append;
    logic load_out;
  } tlru_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic out_free;
  } tlru_status_t;

endpackage
`default_nettype wire

/* rtl/core/tlru_ctrl.sv */
// controller state machine of the two-list lru tracker
`default_nettype none
module tlru_ctrl
  import tlru_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire tlru_status_t status,
  output tlru_cmd_t         cmd
);

  tlru_state_t state;
  tlru_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_REMOVE;
      end
      ST_REMOVE: state_next = ST_APPEND;
      ST_APPEND: state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.clr_we = 1'b1;
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.lookup = in_valid;
      end
      ST_REMOVE: cmd.remove   = 1'b1;
      ST_APPEND: cmd.append   = 1'b1;
      ST_FINISH: cmd.load_out = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/tlru_datapath.sv */
// datapath of the two-list lru tracker: level and link memories, list heads, result register
`default_nettype none
module tlru_datapath
  import tlru_pkg::*;
#(
  parameter int ENTRIES = TLRU_ENTRIES
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tlru_cmd_t        cmd,
  output tlru_status_t          status,
  input  wire logic [IDX_W-1:0] entry_index,
  input  wire logic             func,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [LVL_W-1:0]      new_level,
  output logic                  error,
  output logic                  active_empty,
  output logic [IDX_W-1:0]      active_oldest,
  output logic                  inactive_empty,
  output logic [IDX_W-1:0]      inactive_oldest
);

  localparam int IW = $clog2(ENTRIES);

  typedef struct packed {
    logic [IW-1:0] first;
    logic [IW-1:0] last;
    logic          empty;
  } lane_t;

  logic [LVL_W-1:0] level_mem [ENTRIES];
  logic [IW-1:0]    next_mem  [ENTRIES];
  logic [IW-1:0]    prev_mem  [ENTRIES];

  logic [IW-1:0]    clr_cnt;
  logic [IW-1:0]    req_idx;
  logic             req_func;
  logic             req_ok;
  logic [LVL_W-1:0] lvl_q;
  logic [IW-1:0]    p_q;
  logic [IW-1:0]    n_q;
  logic             ap_act_q;
  logic             ap_ina_q;
  logic [LVL_W-1:0] res_lvl;
  logic             res_err;
  lane_t            act;
  lane_t            ina;

  logic [IW-1:0]    rd_addr;
  logic             rm_act;
  logic             rm_ina;
  logic             ap_act;
  logic             ap_ina;
  logic [LVL_W-1:0] lvl_d;
  logic             err_d;
  lane_t            rm_lane;
  lane_t            rm_lane_next;
  logic             rm_any;
  logic             rm_single;
  lane_t            ap_lane;
  lane_t            ap_lane_next;
  logic             ap_any;

  logic             lv_we;
  logic [IW-1:0]    lv_addr;
  logic [LVL_W-1:0] lv_data;
  logic             nx_we;
  logic [IW-1:0]    nx_addr;
  logic [IW-1:0]    nx_data;
  logic             pv_we;
  logic [IW-1:0]    pv_addr;
  logic [IW-1:0]    pv_data;

  assign rd_addr = IW'(entry_index);

  // clearing sweep of the level store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign status.clr_done = (clr_cnt == IW'(ENTRIES - 1));
  assign status.out_free = !out_valid || !out_stall;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      req_idx  <= rd_addr;
      req_func <= func;
      req_ok   <= (int'(entry_index) < ENTRIES);
    end
  end

  // action plan from the stored level
  always_comb begin
    rm_act = 1'b0;
    rm_ina = 1'b0;
    ap_act = 1'b0;
    ap_ina = 1'b0;
    lvl_d  = LVL_NONE;
    err_d  = 1'b0;
    if (req_ok) begin
      lvl_d = lvl_q;
      if (req_func == FUNC_PROMOTE) begin
        if (lvl_q == LVL_ACTIVE) begin
          rm_act = 1'b1;
          ap_act = 1'b1;
        end else if (lvl_q == LVL_INACTIVE) begin
          rm_ina = 1'b1;
          ap_act = 1'b1;
          lvl_d  = LVL_ACTIVE;
        end else begin
          ap_ina = 1'b1;
          lvl_d  = LVL_INACTIVE;
        end
      end else begin
        if (lvl_q == LVL_ACTIVE) begin
          rm_act = 1'b1;
          ap_ina = 1'b1;
          lvl_d  = LVL_INACTIVE;
        end else if (lvl_q == LVL_INACTIVE) begin
          rm_ina = 1'b1;
          lvl_d  = LVL_NONE;
        end else begin
          err_d = 1'b1;
        end
      end
    end
  end

  // unlink
  assign rm_any    = rm_act || rm_ina;
  assign rm_lane   = rm_act ? act : ina;
  assign rm_single = (rm_lane.first == req_idx) && (rm_lane.last == req_idx);

  always_comb begin
    rm_lane_next = rm_lane;
    if (!rm_lane.empty) begin
      if (rm_single) begin
        rm_lane_next = '{first: '0, last: '0, empty: 1'b1};
      end else begin
        if (rm_lane.first == req_idx) rm_lane_next.first = n_q;
        if (rm_lane.last == req_idx)  rm_lane_next.last  = p_q;
      end
    end
  end

  // tail insert, on the lists as left by the unlink
  assign ap_any  = ap_act_q || ap_ina_q;
  assign ap_lane = ap_act_q ? act : ina;

  always_comb begin
    ap_lane_next = ap_lane;
    if (ap_lane.empty) begin
      ap_lane_next = '{first: req_idx, last: req_idx, empty: 1'b0};
    end else begin
      ap_lane_next.last = req_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.remove) begin
      ap_act_q <= ap_act;
      ap_ina_q <= ap_ina;
      res_lvl  <= lvl_d;
      res_err  <= err_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= '{first: '0, last: '0, empty: 1'b1};
      ina <= '{first: '0, last: '0, empty: 1'b1};
    end else if (cmd.remove) begin
      if (rm_act) act <= rm_lane_next;
      if (rm_ina) ina <= rm_lane_next;
    end else if (cmd.append) begin
      if (ap_act_q) act <= ap_lane_next;
      if (ap_ina_q) ina <= ap_lane_next;
    end
  end

  // memory write selection
  always_comb begin
    lv_we   = cmd.clr_we || (cmd.remove && req_ok && !err_d);
    lv_addr = cmd.clr_we ? clr_cnt : req_idx;
    lv_data = cmd.clr_we ? LVL_NONE : lvl_d;

    nx_we   = 1'b0;
    nx_addr = p_q;
    nx_data = n_q;
    pv_we   = 1'b0;
    pv_addr = n_q;
    pv_data = p_q;
    if (cmd.remove && rm_any && !rm_lane.empty && !rm_single) begin
      nx_we = (rm_lane.first != req_idx);
      pv_we = (rm_lane.last != req_idx);
    end else if (cmd.append && ap_any && !ap_lane.empty) begin
      nx_we   = 1'b1;
      nx_addr = ap_lane.last;
      nx_data = req_idx;
      pv_we   = 1'b1;
      pv_addr = req_idx;
      pv_data = ap_lane.last;
    end
  end

  always_ff @(posedge clk) begin
    if (lv_we) level_mem[lv_addr] <= lv_data;
    if (cmd.lookup) lvl_q <= level_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_addr] <= nx_data;
    if (cmd.lookup) n_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pv_we) prev_mem[pv_addr] <= pv_data;
    if (cmd.lookup) p_q <= prev_mem[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      new_level       <= res_lvl;
      error           <= res_err;
      active_empty    <= act.empty;
      active_oldest   <= act.empty ? '0 : IDX_W'(act.first);
      inactive_empty  <= ina.empty;
      inactive_oldest <= ina.empty ? '0 : IDX_W'(ina.first);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/two_list_lru_tracker_top.sv */
// Two-list lru tracker: an accepted request runs through unlink, tail insert and result
// load into the result register. Items are taken one at a time (lookup, unlink, tail
// insert, result load), set by the single write port of each link memory, which unlink
// and tail insert each need. A stalled result holds the block in its last step until the
// result is taken. Reset (rst, synchronous) empties both lists and then sweeps the level
// store to zero, one entry a cycle through all ENTRIES, with in_stall high during the sweep.
`default_nettype none
module two_list_lru_tracker_top
  import tlru_pkg::*;
#(
  parameter int ENTRIES = TLRU_ENTRIES
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // request channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [IDX_W-1:0] entry_index,
  input  wire logic             func,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [LVL_W-1:0]      new_level,
  output logic                  error,
  output logic                  active_empty,
  output logic [IDX_W-1:0]      active_oldest,
  output logic                  inactive_empty,
  output logic [IDX_W-1:0]      inactive_oldest
);

  // commands from the sequencer, status back from the datapath
  tlru_cmd_t    cmd;
  tlru_status_t status;

  // sequencer: clear sweep, then lookup / unlink / insert / result per item
  tlru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // memories, list head/tail registers and the result register
  tlru_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .entry_index     (entry_index),
    .func            (func),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .new_level       (new_level),
    .error           (error),
    .active_empty    (active_empty),
    .active_oldest   (active_oldest),
    .inactive_empty  (inactive_empty),
    .inactive_oldest (inactive_oldest)
  );

endmodule
`default_nettype wire

/* rtl/core/tlru_checker.sv */
// port-level checks of the two-list lru tracker and their binding
`default_nettype none
module tlru_checker
  import tlru_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [LVL_W-1:0] new_level,
  input wire logic             error,
  input wire logic             active_empty,
  input wire logic             inactive_empty
);

  // one item at a time: after an accept the request side stalls
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while another is in work");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_level) && $stable(error))
    else $error("stalled result changed");

  // an error leaves the entry untracked
  a_error_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> new_level == LVL_NONE)
    else $error("error with a tracked level");

  // an active level comes with a non-empty active list
  a_active_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_level == LVL_ACTIVE |-> !active_empty)
    else $error("active level with empty active list");

  // an inactive level comes with a non-empty inactive list
  a_inactive_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_level == LVL_INACTIVE |-> !inactive_empty)
    else $error("inactive level with empty inactive list");

endmodule

bind two_list_lru_tracker_top tlru_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .new_level      (new_level),
  .error          (error),
  .active_empty   (active_empty),
  .inactive_empty (inactive_empty)
);
`default_nettype wire
